/* src/rc4_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the RC4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

	// Width of one cipher byte and of one state table entry.
	localparam int unsigned ByteW = 8;

	// Entries of the state table and of the key store.
	localparam int unsigned TableDepth = 256;

	// Key bytes held at most; later key bytes are dropped.
	localparam logic [8:0] KEY_MAX = 9'd256;

	// Operation codes carried in the op field of an input item.
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	typedef logic [ByteW-1:0] byte_t;

	// Key byte count; one bit wider than a table index so it can hold KEY_MAX.
	typedef logic [ByteW:0] count_t;

endpackage : rc4_pkg
`default_nettype wire

/* src/rc4_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ifs
// Valid/ready channels of the RC4 core: input items and cipher results.
// ----------------------------------------------------------------------------
interface rc4_item_if;
	logic          valid;
	logic          ready;
	logic          op;
	rc4_pkg::byte_t byte_in;
	logic          key_last;

	modport source (output valid, output op, output byte_in, output key_last, input ready);
	modport sink   (input valid, input op, input byte_in, input key_last, output ready);
endinterface : rc4_item_if

interface rc4_result_if;
	logic          valid;
	logic          ready;
	rc4_pkg::byte_t byte_out;

	modport source (output valid, output byte_out, input ready);
	modport sink   (input valid, input byte_out, output ready);
endinterface : rc4_result_if
`default_nettype wire

/* src/rc4_stream_cipher_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 engine: key load, key schedule and byte-wise encryption/decryption.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the item channel. A key item (op = 0) stores one key byte;
// the key item with key_last set also starts the key schedule over the bytes
// held so far. A data item (op = 1) produces exactly one result transfer on
// the result channel carrying the data byte XORed with the next keystream
// byte. Key items produce no result.
// Sequence: a key item without key_last leaves the item channel ready. A data
// item passes through states D1, D2 and D3 from its transfer to the load of the
// output register, set by three dependent reads of the state memory; the second
// swap write lands with that load, and the next item is taken back in idle.
// The key schedule runs after the last key byte through states K0 to K3 for
// each of the 256 table entries, during which no item is taken.
// Reset: the state table reads as the identity permutation, both indices and
// the key byte count are zero, and no result is pending.
// Stall: the result sits in an output register, so the next item is taken
// while it waits; a data item whose result is ready to be written then waits
// in its last step until the output register is free.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core (
	input  wire           clk,
	input  wire           arst_n,
	rc4_item_if.sink      item,
	rc4_result_if.source  result
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_D1   = 3'd1; // S[i] arrives, read S[j]
	localparam logic [2:0] ST_D2   = 3'd2; // S[j] arrives, write S[i], read S[t]
	localparam logic [2:0] ST_D3   = 3'd3; // keystream arrives, write S[j]
	localparam logic [2:0] ST_K0   = 3'd4; // read S[n] and key[pos]
	localparam logic [2:0] ST_K1   = 3'd5; // accumulate j, read S[j]
	localparam logic [2:0] ST_K2   = 3'd6; // write S[n]
	localparam logic [2:0] ST_K3   = 3'd7; // write S[j], advance n

	localparam int unsigned Depth = rc4_pkg::TableDepth;

	logic [2:0]       state_q;
	rc4_pkg::byte_t   i_q;
	rc4_pkg::byte_t   j_q;
	rc4_pkg::byte_t   acc_q;
	rc4_pkg::byte_t   n_q;
	rc4_pkg::byte_t   pos_q;
	rc4_pkg::count_t  len_q;
	rc4_pkg::count_t  key_count_q;
	rc4_pkg::byte_t   si_q;
	rc4_pkg::byte_t   sj_q;
	rc4_pkg::byte_t   data_q;
	logic             out_vld_q;
	rc4_pkg::byte_t   out_byte_q;

	// State table memory with one read and one write port. Entries whose valid
	// bit is clear read as their own address, which gives the identity table.
	rc4_pkg::byte_t   perm_mem [Depth];
	logic [Depth-1:0] perm_vld_q;
	rc4_pkg::byte_t   perm_rd_q;
	rc4_pkg::byte_t   perm_ra_q;
	logic             perm_vld_rd_q;

	// Key store; only entries written during the current key load are read.
	rc4_pkg::byte_t   key_mem [Depth];
	rc4_pkg::byte_t   key_rd_q;

	logic             accept;
	logic             out_free;
	logic             perm_re;
	rc4_pkg::byte_t   perm_ra;
	logic             perm_we;
	rc4_pkg::byte_t   perm_wa;
	rc4_pkg::byte_t   perm_wd;
	logic             perm_clr;
	rc4_pkg::byte_t   perm_rd;
	rc4_pkg::byte_t   keystream;
	logic             key_store;
	rc4_pkg::count_t  count_next;
	logic             pos_wrap;

	assign item.ready    = (state_q == ST_IDLE);
	assign accept        = item.valid & item.ready;
	assign out_free      = ~out_vld_q | result.ready;
	assign result.valid  = out_vld_q;
	assign result.byte_out = out_byte_q;

	assign perm_rd    = perm_vld_rd_q ? perm_rd_q : perm_ra_q;
	assign key_store  = accept & (item.op == rc4_pkg::OP_KEY) &
		(key_count_q < rc4_pkg::KEY_MAX);
	assign count_next = key_store ? key_count_q + 9'd1 : key_count_q;
	assign perm_clr   = accept & (item.op == rc4_pkg::OP_KEY) & item.key_last;
	assign pos_wrap   = ({1'b0, pos_q} + 9'd1) >= len_q;

	// The read of S[t] in the second step sees the table before the first swap
	// write lands and before the second one is issued; both swapped entries
	// are taken from the registers instead.
	always_comb begin
		if (perm_ra_q == i_q) begin
			keystream = sj_q;
		end else if (perm_ra_q == j_q) begin
			keystream = si_q;
		end else begin
			keystream = perm_rd;
		end
	end

	// Memory port control.
	always_comb begin
		perm_re = 1'b0;
		perm_ra = n_q;
		perm_we = 1'b0;
		perm_wa = n_q;
		perm_wd = perm_rd;
		case (state_q)
			ST_IDLE: begin
				perm_re = accept & (item.op == rc4_pkg::OP_DATA);
				perm_ra = i_q + 8'd1;
			end
			ST_D1: begin
				perm_re = 1'b1;
				perm_ra = j_q + perm_rd;
			end
			ST_D2: begin
				perm_re = 1'b1;
				perm_ra = si_q + perm_rd;
				perm_we = 1'b1;
				perm_wa = i_q;
				perm_wd = perm_rd;
			end
			ST_D3: begin
				perm_we = out_free;
				perm_wa = j_q;
				perm_wd = si_q;
			end
			ST_K0: begin
				perm_re = 1'b1;
				perm_ra = n_q;
			end
			ST_K1: begin
				perm_re = 1'b1;
				perm_ra = acc_q + perm_rd + key_rd_q;
			end
			ST_K2: begin
				perm_we = 1'b1;
				perm_wa = n_q;
				perm_wd = perm_rd;
			end
			ST_K3: begin
				perm_we = 1'b1;
				perm_wa = acc_q;
				perm_wd = si_q;
			end
			default: begin
				perm_re = 1'b0;
				perm_we = 1'b0;
			end
		endcase
	end

	// Memory arrays and their registered read data.
	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_wa] <= perm_wd;
		end
		if (perm_re) begin
			perm_rd_q     <= perm_mem[perm_ra];
			perm_ra_q     <= perm_ra;
			perm_vld_rd_q <= perm_vld_q[perm_ra];
		end
		if (key_store) begin
			key_mem[key_count_q[rc4_pkg::ByteW-1:0]] <= item.byte_in;
		end
		if (state_q == ST_K0) begin
			key_rd_q <= key_mem[pos_q];
		end
	end

	// Valid bits of the state table, cleared at reset and at each key schedule.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_vld_q <= '0;
		end else if (perm_clr) begin
			perm_vld_q <= '0;
		end else if (perm_we) begin
			perm_vld_q[perm_wa] <= 1'b1;
		end
	end

	// Sequencer and index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			acc_q       <= '0;
			n_q         <= '0;
			pos_q       <= '0;
			len_q       <= 9'd1;
			key_count_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			// In the last data step the output register is handled below.
			if (out_vld_q && result.ready && state_q != ST_D3) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && item.op == rc4_pkg::OP_DATA) begin
						i_q     <= i_q + 8'd1;
						state_q <= ST_D1;
					end else if (accept) begin
						key_count_q <= count_next;
						if (item.key_last) begin
							i_q         <= '0;
							j_q         <= '0;
							acc_q       <= '0;
							n_q         <= '0;
							pos_q       <= '0;
							len_q       <= (count_next == '0) ? 9'd1 : count_next;
							key_count_q <= '0;
							state_q     <= ST_K0;
						end
					end
				end
				ST_D1: begin
					j_q     <= j_q + perm_rd;
					state_q <= ST_D2;
				end
				ST_D2: begin
					state_q <= ST_D3;
				end
				ST_D3: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_K0: begin
					state_q <= ST_K1;
				end
				ST_K1: begin
					acc_q   <= acc_q + perm_rd + key_rd_q;
					state_q <= ST_K2;
				end
				ST_K2: begin
					state_q <= ST_K3;
				end
				ST_K3: begin
					n_q   <= n_q + 8'd1;
					pos_q <= pos_wrap ? '0 : pos_q + 8'd1;
					if (n_q == 8'hFF) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_K0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the current item.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= item.byte_in;
		end
		if (state_q == ST_D1 || state_q == ST_K1) begin
			si_q <= perm_rd;
		end
		if (state_q == ST_D2) begin
			sj_q <= perm_rd;
		end
		if (state_q == ST_D3 && out_free) begin
			out_byte_q <= data_q ^ keystream;
		end
	end

`ifndef SYNTHESIS
	a_key_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= rc4_pkg::KEY_MAX)
		else $error("key byte count exceeds its limit");

	a_result_from_d3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_D3)
		else $error("result appeared outside the last data step");

	a_schedule_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.op == rc4_pkg::OP_KEY && item.key_last)
		|=> (state_q == ST_K0 && key_count_q == '0 && perm_vld_q == '0))
		else $error("key schedule did not start from a cleared state");

	a_pos_in_key: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K0) |-> ({1'b0, pos_q} < len_q && len_q != '0))
		else $error("key position outside the received key");
`endif

endmodule : rc4_stream_cipher_core
`default_nettype wire
